### rtl/sts_pkg.sv
`default_nettype none
package sts_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned NumKw = 21;
  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    K_CHAR = 2'd0,
    K_TOKEN = 2'd1,
    K_ERROR = 2'd2
  } res_kind_e;

  typedef enum logic [3:0] {
    M_START, M_WS, M_CR, M_NAME, M_INT, M_FRAC, M_EXP, M_SIGN, M_EXPD,
    M_STR, M_ESC, M_SLASH, M_SL, M_ML, M_MLSTAR, M_ERR
  } scan_mode_e;

  localparam logic [5:0] TkEoi = 6'd0;
  localparam logic [5:0] TkWs = 6'd1;
  localparam logic [5:0] TkLine = 6'd2;
  localparam logic [5:0] TkStr = 6'd10;
  localparam logic [5:0] TkName = 6'd11;
  localparam logic [5:0] TkNum = 6'd12;
  localparam logic [5:0] TkSlc = 6'd13;
  localparam logic [5:0] TkMlc = 6'd14;

  localparam logic [CpW-1:0] ChTab = 21'h09;
  localparam logic [CpW-1:0] ChCr = 21'h0D;
  localparam logic [CpW-1:0] ChLf = 21'h0A;
  localparam logic [CpW-1:0] ChSp = 21'h20;
  localparam logic [CpW-1:0] ChQuote = 21'h22;
  localparam logic [CpW-1:0] ChBslash = 21'h5C;
  localparam logic [CpW-1:0] ChUscore = 21'h5F;
  localparam logic [CpW-1:0] ChDot = 21'h2E;
  localparam logic [CpW-1:0] ChStar = 21'h2A;
  localparam logic [CpW-1:0] ChSlash = 21'h2F;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [CpW-1:0] char_out;
    logic [5:0]     token_kind;
    logic           last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [CpW-1:0] ch;
    logic [5:0]     tk;
  } res_t;

  // keyword text, 8 bits per letter, first letter in the low byte
  function automatic logic [87:0] kw_text(input int unsigned i);
    case (i)
      0:  kw_text = {"", "ssalc"};
      1:  kw_text = "rotcurtsnoc";
      2:  kw_text = {"", "sdnetxe"};
      3:  kw_text = {"", "stnemelpmi"};
      4:  kw_text = {"", "dohtem"};
      5:  kw_text = {"", "erudecorp"};
      6:  kw_text = {"", "evitan"};
      7:  kw_text = {"", "nruter"};
      8:  kw_text = {"", "elbairav"};
      9:  kw_text = {"", "dda"};
      10: kw_text = {"", "tcartbus"};
      11: kw_text = {"", "ylpitlum"};
      12: kw_text = {"", "edivid"};
      13: kw_text = {"", "etagen"};
      14: kw_text = {"", "ton"};
      15: kw_text = {"", "dna"};
      16: kw_text = {"", "ro"};
      17: kw_text = "etanetacnoc";
      18: kw_text = {"", "diov"};
      19: kw_text = {"", "eurt"};
      default: kw_text = {"", "eslaf"};
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned i);
    case (i)
      0: kw_len = 4'd5;   1: kw_len = 4'd11;  2: kw_len = 4'd7;
      3: kw_len = 4'd10;  4: kw_len = 4'd6;   5: kw_len = 4'd9;
      6: kw_len = 4'd6;   7: kw_len = 4'd6;   8: kw_len = 4'd8;
      9: kw_len = 4'd3;   10: kw_len = 4'd8;  11: kw_len = 4'd8;
      12: kw_len = 4'd6;  13: kw_len = 4'd6;  14: kw_len = 4'd3;
      15: kw_len = 4'd3;  16: kw_len = 4'd2;  17: kw_len = 4'd11;
      18: kw_len = 4'd4;  19: kw_len = 4'd4;  default: kw_len = 4'd5;
    endcase
  endfunction

  function automatic logic [5:0] kw_tok(input int unsigned i);
    kw_tok = (i >= 20) ? 6'd34 : 6'(15 + i);
  endfunction

endpackage
`default_nettype wire

### rtl/sts_kw_match.sv
`default_nettype none
module sts_kw_match
  import sts_pkg::*;
(
  input  wire logic [CpW-1:0]   c_i,
  input  wire logic             fresh_i,
  input  wire logic [NumKw-1:0] mask_i,
  input  wire logic [3:0]       len_i,
  output logic [NumKw-1:0]      mask_o,
  output logic [3:0]            len_o,
  output logic [5:0]            tok_o
);

  logic [NumKw-1:0] m_in;
  logic [3:0]       l_in;

  assign m_in = fresh_i ? '1 : mask_i;
  assign l_in = fresh_i ? 4'd0 : len_i;
  assign len_o = (l_in == 4'd15) ? l_in : l_in + 4'd1;

  always_comb begin
    logic [87:0] t;
    logic [7:0]  b;
    for (int i = 0; i < NumKw; i++) begin
      t = kw_text(i);
      b = (l_in < 4'd11) ? t[8*l_in +: 8] : 8'd0;
      mask_o[i] = m_in[i] && (l_in < kw_len(i)) && (c_i == {13'd0, b});
    end
  end

  // token class of a name that ends with the current mask and length
  always_comb begin
    tok_o = TkName;
    for (int i = 0; i < NumKw; i++) begin
      if (mask_i[i] && kw_len(i) == len_i) tok_o = kw_tok(i);
    end
  end

endmodule
`default_nettype wire

### rtl/sts_out_queue.sv
`default_nettype none
module sts_out_queue
  import sts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire res_t [MaxRes-1:0] res_i,
  input  wire logic [1:0] cnt_i,
  output logic           can_load_o,
  output out_item_t      out_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i
);

  res_t [MaxRes-1:0] buf_q;
  logic [1:0] cnt_q, idx_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop = out_valid_o && out_ready_i;
  // accept when empty, or when the final result is leaving now
  assign can_load_o = !out_valid_o || (pop && (idx_q + 2'd1 == cnt_q));

  assign out_o.kind = buf_q[idx_q].kind;
  assign out_o.char_out = buf_q[idx_q].ch;
  assign out_o.token_kind = buf_q[idx_q].tk;
  assign out_o.last = (idx_q + 2'd1 == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
      idx_q <= 2'd0;
    end else if (pop) begin
      if (out_o.last) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= res_i;
  end

endmodule
`default_nettype wire

### rtl/source_token_scanner.sv
`default_nettype none
// Streaming lexical scanner: one code point per request, at most three results
// per request, each marked last on the final one. A request is taken every
// cycle while the result side keeps up; a request with several results holds
// the input until the result side takes its final result. Items yielding no
// result do not load the result queue. After a lexical error input is dropped
// until end of input.
module source_token_scanner
  import sts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output out_item_t      out_data_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i
);

  scan_mode_e       mode_q, mode_d;
  logic [NumKw-1:0] mask_q, mask_d, kw_mask;
  logic [3:0]       len_q, len_d, kw_len_n;
  logic [5:0]       name_tok;
  res_t [MaxRes-1:0] res;
  logic [1:0]       n;
  logic             can_load, acc, fresh, upd_name, load;
  logic [CpW-1:0]   c;
  logic             eoi;

  assign c = in_data_i.code_point;
  assign eoi = in_data_i.end_of_input;
  assign in_ready_o = can_load;
  assign acc = in_valid_i && can_load;
  assign load = acc && n != 2'd0;

  sts_kw_match u_kw (
    .c_i(c), .fresh_i(fresh), .mask_i(mask_q), .len_i(len_q),
    .mask_o(kw_mask), .len_o(kw_len_n), .tok_o(name_tok)
  );

  function automatic logic is_alpha(input logic [CpW-1:0] x);
    is_alpha = (x >= 21'h41 && x <= 21'h5A) || (x >= 21'h61 && x <= 21'h7A);
  endfunction
  function automatic logic is_digit(input logic [CpW-1:0] x);
    is_digit = x >= 21'h30 && x <= 21'h39;
  endfunction

  always_comb begin
    logic [5:0] p;
    mode_d = mode_q;
    mask_d = mask_q;
    len_d = len_q;
    res = '0;
    n = 2'd0;
    fresh = 1'b0;
    upd_name = 1'b0;
    p = 6'd0;

    // finish/dispatch handled by a two-phase walk: phase 0 handles the mode,
    // phase 1 (dispatch) runs when the current token ended on this char, or in start mode
    begin
      logic do_disp;
      logic [5:0] fin_tk;
      logic do_fin;
      do_disp = 1'b0;
      do_fin = 1'b0;
      fin_tk = 6'd0;
      unique case (mode_q)
        M_WS: if (eoi || (c != ChSp && c != ChTab)) begin
          do_fin = 1'b1; fin_tk = TkWs;
        end
        M_CR: if (!eoi && c == ChLf) begin
          res[0] = '{K_TOKEN, '0, TkLine}; n = 2'd1; mode_d = M_START;
        end else begin
          do_fin = 1'b1; fin_tk = TkLine;
        end
        M_NAME: if (!eoi && (c == ChUscore || is_alpha(c) || is_digit(c))) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; upd_name = 1'b1;
        end else begin
          do_fin = 1'b1; fin_tk = name_tok;
          mask_d = '1; len_d = 4'd0;
        end
        M_INT: if (!eoi && is_digit(c)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1;
        end else if (!eoi && c == ChDot) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; mode_d = M_FRAC;
        end else begin
          do_fin = 1'b1; fin_tk = TkNum;
        end
        M_FRAC: if (!eoi && is_digit(c)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1;
        end else if (!eoi && (c == 21'h65 || c == 21'h45)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; mode_d = M_EXP;
        end else begin
          do_fin = 1'b1; fin_tk = TkNum;
        end
        M_EXP: if (!eoi && (c == 21'h2B || c == 21'h2D)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; mode_d = M_SIGN;
        end else if (!eoi && is_digit(c)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; mode_d = M_EXPD;
        end else begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = eoi ? M_START : M_ERR;
        end
        M_SIGN: if (!eoi && is_digit(c)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; mode_d = M_EXPD;
        end else begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = eoi ? M_START : M_ERR;
        end
        M_EXPD: if (!eoi && is_digit(c)) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1;
        end else begin
          do_fin = 1'b1; fin_tk = TkNum;
        end
        M_STR: if (eoi) begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = M_START;
        end else if (c == ChBslash) begin
          mode_d = M_ESC;
        end else if (c == ChQuote) begin
          res[0] = '{K_TOKEN, '0, TkStr}; n = 2'd1; mode_d = M_START;
        end else begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1;
        end
        M_ESC: if (eoi) begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = M_START;
        end else if (c == ChQuote || c == ChBslash) begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1; mode_d = M_STR;
        end else if (c == 21'h6E) begin
          res[0] = '{K_CHAR, ChLf, 6'd0}; n = 2'd1; mode_d = M_STR;
        end else if (c == 21'h72) begin
          res[0] = '{K_CHAR, ChCr, 6'd0}; n = 2'd1; mode_d = M_STR;
        end else begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = M_ERR;
        end
        M_SLASH: if (eoi) begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = M_START;
        end else if (c == ChStar) begin
          mode_d = M_ML;
        end else if (c == ChSlash) begin
          mode_d = M_SL;
        end else begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = M_ERR;
        end
        M_SL: if (eoi || c == ChLf || c == ChCr) begin
          do_fin = 1'b1; fin_tk = TkSlc;
        end else begin
          res[0] = '{K_CHAR, c, 6'd0}; n = 2'd1;
        end
        M_ML: if (eoi) begin
          res[0] = '{K_ERROR, '0, 6'd0}; n = 2'd1; mode_d = M_START;
        end else if (c == ChStar) begin
          mode_d = M_MLSTAR;
        end
        M_MLSTAR: if (!eoi && c == ChSlash) begin
          res[0] = '{K_TOKEN, '0, TkMlc}; n = 2'd1; mode_d = M_START;
        end else begin
          res[0] = '{K_CHAR, ChStar, 6'd0}; n = 2'd1;
          if (eoi) begin
            res[1] = '{K_ERROR, '0, 6'd0}; n = 2'd2; mode_d = M_START;
          end else if (c != ChStar) begin
            mode_d = M_ML;
          end
        end
        M_ERR: if (eoi) begin
          res[0] = '{K_TOKEN, '0, TkEoi}; n = 2'd1; mode_d = M_START;
        end
        default: if (eoi) begin
          res[0] = '{K_TOKEN, '0, TkEoi}; n = 2'd1; mode_d = M_START;
        end else begin
          do_disp = 1'b1;
        end
      endcase

      if (do_fin) begin
        res[0] = '{K_TOKEN, '0, fin_tk}; n = 2'd1; mode_d = M_START;
        if (eoi) begin
          res[1] = '{K_TOKEN, '0, TkEoi}; n = 2'd2;
        end else begin
          do_disp = 1'b1;
        end
      end

      if (do_disp) begin
        mode_d = M_START;
        case (c)
          21'h3D: p = 6'd3;
          21'h3A: p = 6'd4;
          21'h2C: p = 6'd5;
          21'h7B: p = 6'd6;
          21'h7D: p = 6'd7;
          21'h28: p = 6'd8;
          21'h29: p = 6'd9;
          default: p = 6'd0;
        endcase
        if (c == ChSp || c == ChTab) begin
          mode_d = M_WS;
        end else if (c == ChCr) begin
          mode_d = M_CR;
        end else if (c == ChLf) begin
          res[n] = '{K_TOKEN, '0, TkLine}; n = n + 2'd1;
        end else if (p != 6'd0) begin
          res[n] = '{K_CHAR, c, 6'd0};
          res[n + 2'd1] = '{K_TOKEN, '0, p}; n = n + 2'd2;
        end else if (c == ChQuote) begin
          mode_d = M_STR;
        end else if (c == ChUscore || is_alpha(c)) begin
          res[n] = '{K_CHAR, c, 6'd0}; n = n + 2'd1;
          fresh = 1'b1; upd_name = 1'b1; mode_d = M_NAME;
        end else if (is_digit(c)) begin
          res[n] = '{K_CHAR, c, 6'd0}; n = n + 2'd1; mode_d = M_INT;
        end else if (c == ChSlash) begin
          mode_d = M_SLASH;
        end else begin
          res[n] = '{K_ERROR, '0, 6'd0}; n = n + 2'd1; mode_d = M_ERR;
        end
      end
    end

    if (upd_name) begin
      mask_d = kw_mask;
      len_d = kw_len_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START;
      mask_q <= '1;
      len_q <= 4'd0;
    end else if (acc) begin
      mode_q <= mode_d;
      mask_q <= mask_d;
      len_q <= len_d;
    end
  end

  sts_out_queue u_q (
    .clk_i(clk_i), .rst_ni(rst_ni), .load_i(load), .res_i(res), .cnt_i(n),
    .can_load_o(can_load), .out_o(out_data_o), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

endmodule
`default_nettype wire

### tb/source_token_scanner_tb.sv
`timescale 1ns / 1ps
module source_token_scanner_tb;
  import sts_pkg::*;

  localparam int unsigned WatchLimit = 5000;

  typedef struct packed {
    logic [1:0]     kind;
    logic [CpW-1:0] ch;
    logic [5:0]     tk;
    logic           last;
  } lex_res_t;

  class lexeme_scoreboard;
    scan_mode_e   mode;
    logic [20:0]  kw_mask;
    logic [3:0]   name_len;
    lex_res_t     pending[$];
    lex_res_t     step_res[$];

    function new();
      mode = M_START;
      kw_mask = '1;
      name_len = '0;
    endfunction

    function void push(logic [1:0] k, logic [CpW-1:0] c, logic [5:0] t);
      lex_res_t r;
      if (step_res.size() >= MaxRes) return;
      r.kind = k;
      r.ch = k == K_CHAR ? c : '0;
      r.tk = k == K_TOKEN ? t : '0;
      r.last = 1'b0;
      step_res.push_back(r);
    endfunction

    function bit letter(logic [CpW-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit(logic [CpW-1:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void name_grow(logic [CpW-1:0] c);
      logic [87:0] txt;
      for (int i = 0; i < NumKw; i++) begin
        txt = kw_text(i);
        if (name_len >= kw_len(i) || {13'd0, txt[8*name_len +: 8]} != c)
          kw_mask[i] = 1'b0;
      end
      if (name_len != 4'd15) name_len++;
    endfunction

    function logic [5:0] name_close();
      logic [5:0] t;
      t = TkName;
      for (int i = 0; i < NumKw; i++)
        if (kw_mask[i] && kw_len(i) == name_len) t = kw_tok(i);
      kw_mask = '1;
      name_len = '0;
      return t;
    endfunction

    function void lex_error(bit eoi);
      push(K_ERROR, '0, '0);
      mode = eoi ? M_START : M_ERR;
    endfunction

    function void begin_token(logic [CpW-1:0] c);
      logic [5:0] p;
      bit punct;
      mode = M_START;
      punct = 1'b1;
      case (c)
        "=": p = 6'd3;
        ":": p = 6'd4;
        ",": p = 6'd5;
        "{": p = 6'd6;
        "}": p = 6'd7;
        "(": p = 6'd8;
        ")": p = 6'd9;
        default: begin
          punct = 1'b0;
          p = '0;
        end
      endcase
      if (c == ChSp || c == ChTab) mode = M_WS;
      else if (c == ChCr) mode = M_CR;
      else if (c == ChLf) push(K_TOKEN, '0, TkLine);
      else if (punct) begin
        push(K_CHAR, c, '0);
        push(K_TOKEN, '0, p);
      end else if (c == ChQuote) mode = M_STR;
      else if (c == ChUscore || letter(c)) begin
        kw_mask = '1;
        name_len = '0;
        push(K_CHAR, c, '0);
        name_grow(c);
        mode = M_NAME;
      end else if (digit(c)) begin
        push(K_CHAR, c, '0);
        mode = M_INT;
      end else if (c == ChSlash) mode = M_SLASH;
      else lex_error(1'b0);
    endfunction

    function void close_token(logic [5:0] t, logic [CpW-1:0] c, bit eoi);
      push(K_TOKEN, '0, t);
      mode = M_START;
      if (eoi) push(K_TOKEN, '0, TkEoi);
      else begin_token(c);
    endfunction

    function void note_request(in_item_t it);
      logic [CpW-1:0] c;
      bit eoi;
      c = it.code_point;
      eoi = it.end_of_input;
      step_res.delete();
      case (mode)
        M_WS: if (eoi || (c != ChSp && c != ChTab)) close_token(TkWs, c, eoi);
        M_CR:
          if (!eoi && c == ChLf) begin
            push(K_TOKEN, '0, TkLine);
            mode = M_START;
          end else close_token(TkLine, c, eoi);
        M_NAME:
          if (!eoi && (c == ChUscore || letter(c) || digit(c))) begin
            push(K_CHAR, c, '0);
            name_grow(c);
          end else close_token(name_close(), c, eoi);
        M_INT:
          if (!eoi && digit(c)) push(K_CHAR, c, '0);
          else if (!eoi && c == ChDot) begin
            push(K_CHAR, c, '0);
            mode = M_FRAC;
          end else close_token(TkNum, c, eoi);
        M_FRAC:
          if (!eoi && digit(c)) push(K_CHAR, c, '0);
          else if (!eoi && (c == "e" || c == "E")) begin
            push(K_CHAR, c, '0);
            mode = M_EXP;
          end else close_token(TkNum, c, eoi);
        M_EXP:
          if (!eoi && (c == "+" || c == "-")) begin
            push(K_CHAR, c, '0);
            mode = M_SIGN;
          end else if (!eoi && digit(c)) begin
            push(K_CHAR, c, '0);
            mode = M_EXPD;
          end else lex_error(eoi);
        M_SIGN:
          if (!eoi && digit(c)) begin
            push(K_CHAR, c, '0);
            mode = M_EXPD;
          end else lex_error(eoi);
        M_EXPD:
          if (!eoi && digit(c)) push(K_CHAR, c, '0);
          else close_token(TkNum, c, eoi);
        M_STR:
          if (eoi) lex_error(1'b1);
          else if (c == ChBslash) mode = M_ESC;
          else if (c == ChQuote) begin
            push(K_TOKEN, '0, TkStr);
            mode = M_START;
          end else push(K_CHAR, c, '0);
        M_ESC:
          if (eoi) lex_error(1'b1);
          else if (c == ChQuote || c == ChBslash) begin
            push(K_CHAR, c, '0);
            mode = M_STR;
          end else if (c == "n") begin
            push(K_CHAR, ChLf, '0);
            mode = M_STR;
          end else if (c == "r") begin
            push(K_CHAR, ChCr, '0);
            mode = M_STR;
          end else lex_error(1'b0);
        M_SLASH:
          if (eoi) lex_error(1'b1);
          else if (c == ChStar) mode = M_ML;
          else if (c == ChSlash) mode = M_SL;
          else lex_error(1'b0);
        M_SL:
          if (eoi || c == ChLf || c == ChCr) close_token(TkSlc, c, eoi);
          else push(K_CHAR, c, '0);
        M_ML:
          if (eoi) lex_error(1'b1);
          else if (c == ChStar) mode = M_MLSTAR;
        M_MLSTAR:
          if (!eoi && c == ChSlash) begin
            push(K_TOKEN, '0, TkMlc);
            mode = M_START;
          end else begin
            push(K_CHAR, ChStar, '0);
            if (eoi) lex_error(1'b1);
            else if (c != ChStar) mode = M_ML;
          end
        M_ERR:
          if (eoi) begin
            push(K_TOKEN, '0, TkEoi);
            mode = M_START;
          end
        default:
          if (eoi) push(K_TOKEN, '0, TkEoi);
          else begin_token(c);
      endcase
      if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
      foreach (step_res[i]) pending.push_back(step_res[i]);
    endfunction

    function bit check_result(out_item_t got, output lex_res_t want);
      if (pending.size() == 0) begin
        want = '0;
        return 1'b0;
      end
      want = pending.pop_front();
      return got.kind == want.kind && got.char_out == want.ch &&
             got.token_kind == want.tk && got.last == want.last;
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  in_item_t  in_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  out_item_t out_data_o;
  logic      out_valid_o;
  logic      out_ready_i;

  source_token_scanner DUT (.*);

  lexeme_scoreboard sb;
  int  mismatches;
  int  send_idle, recv_stall;
  int  quiet_cycles;
  in_item_t src_q[$];

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: sample on rise, change ready on fall
  always @(posedge clk_i) begin
    lex_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sb.pending.size() == 0)
          report_mismatch($sformatf("unexpected result %h", out_data_o));
        else if (!sb.check_result(out_data_o, want))
          report_mismatch($sformatf("got %h want %h", out_data_o, want));
      end
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_stall);

  // valid stays high into the next request unless the sender idles
  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_text(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.code_point = {13'd0, s[i]};
      it.end_of_input = 1'b0;
      src_q.push_back(it);
    end
  endtask

  task automatic queue_cp(logic [CpW-1:0] c, bit eoi);
    in_item_t it;
    it.code_point = c;
    it.end_of_input = eoi;
    src_q.push_back(it);
  endtask

  function automatic string random_lexeme();
    string words[$] = '{"class", "constructor", "extends", "implements", "method",
      "procedure", "native", "return", "variable", "add", "subtract", "multiply",
      "divide", "negate", "not", "and", "or", "concatenate", "void", "true",
      "false", "x_1", "classy", "an", "_q9", "abcdefghijklmnopq", "12", "3.5",
      "7.e+4", "1.2E9", "0.", "\"a\\n\\\"\\\\\\r\"", "// hi\n", "/* a ** b */",
      "=", ":", ",", "{", "}", "(", ")", " \t ", "\r\n", "\r", "\n"};
    return words[$urandom_range(words.size() - 1)];
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    int sent;
    send_idle = idle;
    recv_stall = stall;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0: queue_cp(CpW'($urandom_range(32'h1FFFFF)), 1'b0);
        1: queue_cp(CpW'($urandom_range(127)), 1'b0);
        default: begin
          queue_text(random_lexeme());
          if ($urandom_range(1)) queue_text(" ");
        end
      endcase
      if ($urandom_range(15) == 0) queue_cp(CpW'($urandom_range(32'h1FFFFF)), 1'b1);
      while (src_q.size() > 0) begin
        send_request(src_q.pop_front());
        sent++;
      end
    end
    queue_cp(CpW'($urandom_range(32'h1FFFFF)), 1'b1);
    while (src_q.size() > 0) send_request(src_q.pop_front());
  endtask

  initial begin
    sb = new();
    mismatches = 0;
    quiet_cycles = 0;
    send_idle = 0;
    recv_stall = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: a keyword, all non-keyword token kinds, escapes, comment edges, errors
    queue_text("class x=1.5e-3,{}():\"q\\\"\\\\\\n\\r\"\r\n\r\t/*a**/ //c\r");
    queue_cp(21'h1FFFFF, 1'b0);
    queue_cp(21'h000000, 1'b1);
    queue_text("\"\\x");
    queue_cp('0, 1'b1);
    queue_text("/* *");
    queue_cp(21'h1FFFFF, 1'b1);
    queue_text("1.e");
    queue_cp('0, 1'b1);
    queue_text("/");
    queue_cp('0, 1'b1);
    while (src_q.size() > 0) send_request(src_q.pop_front());

    run_phase(40, 0, 0);
    run_phase(40, 68, 0);
    run_phase(40, 0, 68);
    run_phase(40, 23, 23);
    in_valid_i <= 1'b0;

    while (sb.pending.size() > 0 && quiet_cycles < WatchLimit) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/sts_pkg.sv
rtl/sts_kw_match.sv
rtl/sts_out_queue.sv
rtl/source_token_scanner.sv
tb/source_token_scanner_tb.sv
